// ----- rtl/llm_pkg.sv -----
// ----------------------------------------------------------------------------
// llm_pkg
// Shared types and constants for the linked list manager: slot and link
// widths, opcodes, result status codes, controller states, command/status.
// ----------------------------------------------------------------------------
package llm_pkg;

   localparam int CAPACITY = 256;
   localparam int SLOT_W   = 8;
   localparam int LINK_W   = 9;
   localparam int DATA_W   = 64;
   localparam int COUNT_W  = 9;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [LINK_W-1:0]  link_type;
   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [COUNT_W-1:0] count_type;

   // all ones in a link means no slot
   localparam link_type NO_SLOT = '1;

   typedef enum logic [2:0] {
      OP_INS_BEFORE = 3'd0,
      OP_INS_AFTER  = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_PUSH_BACK  = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_READ       = 3'd5,
      OP_REVERSE    = 3'd6,
      OP_NONE       = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOT_USED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_EXEC,
      S_LINK,
      S_REV_RD,
      S_REV_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic mem_read;
      logic rev_sel;
      logic exec;
      logic link;
      logic rev_write;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic err;
      logic needs_link;
      logic is_reverse;
      logic rev_last;
   } dp_sts_type;

endpackage

// ----- rtl/llm_if.sv -----
// ----------------------------------------------------------------------------
// llm_req_if / llm_rsp_if
// Valid/ready channels carrying one request transaction and one response
// transaction of the linked list manager.
// ----------------------------------------------------------------------------
interface llm_req_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   opcode;
   logic [llm_pkg::SLOT_W-1:0]   position;
   logic [llm_pkg::DATA_W-1:0]   data_in;

   modport source (output valid, output opcode, output position, output data_in,
                   input ready);
   modport sink   (input valid, input opcode, input position, input data_in,
                   output ready);
endinterface

interface llm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic [llm_pkg::DATA_W-1:0]         data_out;
   logic signed [llm_pkg::LINK_W-1:0]  prev_slot;
   logic signed [llm_pkg::LINK_W-1:0]  next_slot;
   logic signed [llm_pkg::LINK_W-1:0]  slot_used;
   logic signed [llm_pkg::LINK_W-1:0]  head_slot;
   logic signed [llm_pkg::LINK_W-1:0]  tail_slot;
   logic [llm_pkg::COUNT_W-1:0]        element_count;

   modport source (output valid, output status, output data_out, output prev_slot,
                   output next_slot, output slot_used, output head_slot,
                   output tail_slot, output element_count, input ready);
   modport sink   (input valid, input status, input data_out, input prev_slot,
                   input next_slot, input slot_used, input head_slot,
                   input tail_slot, input element_count, output ready);
endinterface

// ----- rtl/llm_datapath.sv -----
// ----------------------------------------------------------------------------
// llm_datapath
// Slot store, link memories, list pointers and the response register.
// Executes the commands issued by the controller.
// ----------------------------------------------------------------------------
module llm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  llm_pkg::dp_cmd_type cmd,
   output llm_pkg::dp_sts_type sts,
   input  logic [2:0]          req_opcode,
   input  llm_pkg::slot_type   req_position,
   input  llm_pkg::data_type   req_data_in,
   output logic [1:0]          rsp_status,
   output llm_pkg::data_type   rsp_data_out,
   output llm_pkg::link_type   rsp_prev_slot,
   output llm_pkg::link_type   rsp_next_slot,
   output llm_pkg::link_type   rsp_slot_used,
   output llm_pkg::link_type   rsp_head_slot,
   output llm_pkg::link_type   rsp_tail_slot,
   output llm_pkg::count_type  rsp_element_count
);
   import llm_pkg::*;

   opcode_type op_ff;
   slot_type   pos_ff;
   data_type   din_ff;

   link_type  head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   count_type count_ff, count_in;
   link_type  cur_ff, cur_in;
   count_type k_ff, k_in;

   logic [CAPACITY-1:0] in_use_ff;
   logic [CAPACITY-1:0] next_vld_ff;

   data_type value_mem [CAPACITY];
   link_type prev_mem  [CAPACITY];
   link_type next_mem  [CAPACITY];

   data_type val_rd_ff;
   link_type prev_rd_ff, next_a_raw_ff, next_b_raw_ff;
   slot_type next_a_addr_ff, next_b_addr_ff;
   logic     next_a_vld_ff, next_b_vld_ff;
   logic     live_ff;
   link_type next_a, next_b;
   slot_type rd_a_addr, rd_p_addr;

   link_type lk_p_ff, lk_p_in, lk_n_ff, lk_n_in, lk_s_ff, lk_s_in;

   status_type st;
   status_type res_st_ff, res_st_in;
   data_type   res_dout_ff, res_dout_in;
   link_type   res_pl_ff, res_pl_in, res_nl_ff, res_nl_in, res_used_ff, res_used_in;

   status_type rsp_st_ff;
   data_type   rsp_dout_ff;
   link_type   rsp_pl_ff, rsp_nl_ff, rsp_used_ff, rsp_head_ff, rsp_tail_ff;
   count_type  rsp_count_ff;

   logic     is_ins, empty, full, live, rev_last;
   link_type ins_p, ins_n;

   logic     val_we, prev_we, next_we, use_set, use_clr;
   slot_type val_wa, prev_wa, next_wa, use_addr;
   link_type prev_wd, next_wd;

   // free chain default: entry i points to i+1, the last entry to none
   function automatic link_type chain_dflt(input slot_type a);
      link_type r;
      if (a == slot_type'(CAPACITY - 1)) begin
         r = NO_SLOT;
      end else begin
         r = link_type'(a) + link_type'(1);
      end
      return r;
   endfunction

   assign rd_a_addr = cmd.rev_sel ? cur_ff[SLOT_W-1:0] : free_ff[SLOT_W-1:0];
   assign rd_p_addr = cmd.rev_sel ? cur_ff[SLOT_W-1:0] : pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         val_rd_ff      <= value_mem[pos_ff];
         prev_rd_ff     <= prev_mem[rd_p_addr];
         next_a_raw_ff  <= next_mem[rd_a_addr];
         next_b_raw_ff  <= next_mem[pos_ff];
         next_a_addr_ff <= rd_a_addr;
         next_b_addr_ff <= pos_ff;
         next_a_vld_ff  <= next_vld_ff[rd_a_addr];
         next_b_vld_ff  <= next_vld_ff[pos_ff];
         live_ff        <= in_use_ff[pos_ff];
      end
   end

   assign next_a = next_a_vld_ff ? next_a_raw_ff : chain_dflt(next_a_addr_ff);
   assign next_b = next_b_vld_ff ? next_b_raw_ff : chain_dflt(next_b_addr_ff);

   // status checks
   assign empty  = (count_ff == '0);
   assign full   = free_ff[LINK_W-1];
   assign live   = live_ff;
   assign is_ins = (op_ff == OP_INS_BEFORE) || (op_ff == OP_INS_AFTER) ||
                   (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_BACK);

   always_comb begin
      unique case (op_ff)
         OP_INS_BEFORE, OP_INS_AFTER: begin
            if (full) st = ST_FULL;
            else if (!empty && !live) st = ST_NOT_USED;
            else st = ST_OK;
         end
         OP_PUSH_FRONT, OP_PUSH_BACK: st = full ? ST_FULL : ST_OK;
         OP_REMOVE, OP_READ: begin
            if (empty) st = ST_EMPTY;
            else if (!live) st = ST_NOT_USED;
            else st = ST_OK;
         end
         OP_REVERSE: st = empty ? ST_EMPTY : ST_OK;
         OP_NONE:    st = ST_OK;
         default:    st = ST_OK;
      endcase
   end

   // neighbors of a new element
   always_comb begin
      ins_p = NO_SLOT;
      ins_n = NO_SLOT;
      unique case (op_ff)
         OP_INS_BEFORE: begin
            if (!empty) begin
               ins_p = prev_rd_ff;
               ins_n = link_type'(pos_ff);
            end
         end
         OP_INS_AFTER: begin
            if (!empty) begin
               ins_p = link_type'(pos_ff);
               ins_n = next_b;
            end
         end
         OP_PUSH_FRONT: ins_n = head_ff;
         OP_PUSH_BACK:  ins_p = tail_ff;
         default: ;
      endcase
   end

   assign rev_last = ((k_ff + count_type'(1)) == count_ff) || next_a[LINK_W-1];

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      k_in        = k_ff;
      lk_p_in     = lk_p_ff;
      lk_n_in     = lk_n_ff;
      lk_s_in     = lk_s_ff;
      res_st_in   = res_st_ff;
      res_dout_in = res_dout_ff;
      res_pl_in   = res_pl_ff;
      res_nl_in   = res_nl_ff;
      res_used_in = res_used_ff;
      val_we      = 1'b0;
      val_wa      = '0;
      prev_we     = 1'b0;
      prev_wa     = '0;
      prev_wd     = '0;
      next_we     = 1'b0;
      next_wa     = '0;
      next_wd     = '0;
      use_set     = 1'b0;
      use_clr     = 1'b0;
      use_addr    = '0;

      if (cmd.exec) begin
         res_st_in   = st;
         res_dout_in = '0;
         res_pl_in   = NO_SLOT;
         res_nl_in   = NO_SLOT;
         res_used_in = NO_SLOT;
         if (st == ST_OK) begin
            if (is_ins) begin
               // new element takes the head of the free chain
               res_dout_in = din_ff;
               res_pl_in   = ins_p;
               res_nl_in   = ins_n;
               res_used_in = free_ff;
               lk_p_in     = ins_p;
               lk_n_in     = ins_n;
               lk_s_in     = free_ff;
               free_in     = next_a;
               if (ins_p[LINK_W-1]) head_in = free_ff;
               if (ins_n[LINK_W-1]) tail_in = free_ff;
               count_in    = count_ff + count_type'(1);
               val_we      = 1'b1;
               val_wa      = free_ff[SLOT_W-1:0];
               prev_we     = 1'b1;
               prev_wa     = free_ff[SLOT_W-1:0];
               prev_wd     = ins_p;
               next_we     = 1'b1;
               next_wa     = free_ff[SLOT_W-1:0];
               next_wd     = ins_n;
               use_set     = 1'b1;
               use_addr    = free_ff[SLOT_W-1:0];
            end else begin
               unique case (op_ff)
                  OP_REMOVE: begin
                     res_dout_in = val_rd_ff;
                     res_pl_in   = prev_rd_ff;
                     res_nl_in   = next_b;
                     lk_p_in     = prev_rd_ff;
                     lk_n_in     = next_b;
                     if (prev_rd_ff[LINK_W-1]) head_in = next_b;
                     if (next_b[LINK_W-1]) tail_in = prev_rd_ff;
                     use_clr     = 1'b1;
                     use_addr    = pos_ff;
                     // freed slot goes to the front of the free chain
                     next_we     = 1'b1;
                     next_wa     = pos_ff;
                     next_wd     = free_ff;
                     free_in     = link_type'(pos_ff);
                     count_in    = count_ff - count_type'(1);
                  end
                  OP_READ: begin
                     res_dout_in = val_rd_ff;
                     res_pl_in   = prev_rd_ff;
                     res_nl_in   = next_b;
                  end
                  OP_REVERSE: begin
                     cur_in = head_ff;
                     k_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
      end

      // stitch the neighbors of the inserted or removed slot
      if (cmd.link) begin
         if (!lk_p_ff[LINK_W-1]) begin
            next_we = 1'b1;
            next_wa = lk_p_ff[SLOT_W-1:0];
            next_wd = (op_ff == OP_REMOVE) ? lk_n_ff : lk_s_ff;
         end
         if (!lk_n_ff[LINK_W-1]) begin
            prev_we = 1'b1;
            prev_wa = lk_n_ff[SLOT_W-1:0];
            prev_wd = (op_ff == OP_REMOVE) ? lk_p_ff : lk_s_ff;
         end
      end

      // one element of the reverse walk: swap its links
      if (cmd.rev_write) begin
         next_we = 1'b1;
         next_wa = cur_ff[SLOT_W-1:0];
         next_wd = prev_rd_ff;
         prev_we = 1'b1;
         prev_wa = cur_ff[SLOT_W-1:0];
         prev_wd = next_a;
         cur_in  = next_a;
         k_in    = k_ff + count_type'(1);
         if (rev_last) begin
            head_in = tail_ff;
            tail_in = head_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (val_we) value_mem[val_wa] <= din_ff;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= NO_SLOT;
         tail_ff     <= NO_SLOT;
         free_ff     <= '0;
         count_ff    <= '0;
         cur_ff      <= NO_SLOT;
         k_ff        <= '0;
         in_use_ff   <= '0;
         next_vld_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         k_ff     <= k_in;
         if (use_set) in_use_ff[use_addr] <= 1'b1;
         if (use_clr) in_use_ff[use_addr] <= 1'b0;
         if (next_we) next_vld_ff[next_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= opcode_type'(req_opcode);
         pos_ff <= req_position;
         din_ff <= req_data_in;
      end
      lk_p_ff     <= lk_p_in;
      lk_n_ff     <= lk_n_in;
      lk_s_ff     <= lk_s_in;
      res_st_ff   <= res_st_in;
      res_dout_ff <= res_dout_in;
      res_pl_ff   <= res_pl_in;
      res_nl_ff   <= res_nl_in;
      res_used_ff <= res_used_in;
      if (cmd.load_rsp) begin
         rsp_st_ff    <= res_st_ff;
         rsp_dout_ff  <= res_dout_ff;
         rsp_pl_ff    <= res_pl_ff;
         rsp_nl_ff    <= res_nl_ff;
         rsp_used_ff  <= res_used_ff;
         rsp_head_ff  <= head_ff;
         rsp_tail_ff  <= tail_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign sts.err        = (st != ST_OK);
   assign sts.needs_link = is_ins || (op_ff == OP_REMOVE);
   assign sts.is_reverse = (op_ff == OP_REVERSE);
   assign sts.rev_last   = rev_last;

   assign rsp_status        = rsp_st_ff;
   assign rsp_data_out      = rsp_dout_ff;
   assign rsp_prev_slot     = rsp_pl_ff;
   assign rsp_next_slot     = rsp_nl_ff;
   assign rsp_slot_used     = rsp_used_ff;
   assign rsp_head_slot     = rsp_head_ff;
   assign rsp_tail_slot     = rsp_tail_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

// ----- rtl/llm_controller.sv -----
// ----------------------------------------------------------------------------
// llm_controller
// Sequencer for the linked list manager: steps each request through decode,
// execute, neighbor link update or reverse walk, and response load.
// ----------------------------------------------------------------------------
module llm_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  llm_pkg::dp_sts_type sts,
   output llm_pkg::dp_cmd_type cmd
);
   import llm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // response register can take a new transaction
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.mem_read = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.err) state_in = S_DONE;
            else if (sts.needs_link) state_in = S_LINK;
            else if (sts.is_reverse) state_in = S_REV_RD;
            else state_in = S_DONE;
         end
         S_LINK: begin
            cmd.link = 1'b1;
            state_in = S_DONE;
         end
         S_REV_RD: begin
            cmd.mem_read = 1'b1;
            cmd.rev_sel  = 1'b1;
            state_in     = S_REV_WR;
         end
         S_REV_WR: begin
            cmd.rev_write = 1'b1;
            state_in      = sts.rev_last ? S_DONE : S_REV_RD;
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               // next request may start while this response is loaded
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = S_DECODE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/linked_list_manager_unit.sv -----
// ----------------------------------------------------------------------------
// linked_list_manager_unit
// Doubly linked list of 256 slots with a free chain, driven by one request
// channel and answered on one response channel.
// ----------------------------------------------------------------------------
// usage
//   req_chan carries opcode, position and data_in; rsp_chan returns status,
//   data_out, the slot links, the slot taken and head, tail and count after
//   the operation; one response transaction per request transaction
//   a request is taken when valid and ready are both high on a rising edge
//   steps per request, from acceptance to acceptance of the next:
//     insert, push and remove: decode read, execute, neighbor link, load
//     read, no-op and any error: decode read, execute, load
//     reverse: decode read, execute, a read and a write per element, load
//   the separate steps follow from the single write port of each link memory and
//   the registered read of the link memories
//   the response sits in an output register; the next request is accepted
//   while it waits, and the block holds in its load state only when a
//   finished response finds the register still full
//   synchronous reset empties the list: head and tail none, count zero,
//   free chain rebuilt at once through per-slot valid bits, no clearing pass
// ----------------------------------------------------------------------------
module linked_list_manager_unit (
   input logic       clock,
   input logic       reset,
   llm_req_if.sink   req_chan,
   llm_rsp_if.source rsp_chan
);
   import llm_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type cmd;
   dp_sts_type sts;

   link_type  prev_slot_w, next_slot_w, slot_used_w, head_slot_w, tail_slot_w;
   count_type count_w;
   data_type  data_out_w;
   logic [1:0] status_w;

   llm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   llm_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_chan.opcode),
      .req_position      (req_chan.position),
      .req_data_in       (req_chan.data_in),
      .rsp_status        (status_w),
      .rsp_data_out      (data_out_w),
      .rsp_prev_slot     (prev_slot_w),
      .rsp_next_slot     (next_slot_w),
      .rsp_slot_used     (slot_used_w),
      .rsp_head_slot     (head_slot_w),
      .rsp_tail_slot     (tail_slot_w),
      .rsp_element_count (count_w)
   );

   // links travel as two's complement, all ones meaning none
   assign rsp_chan.status        = status_w;
   assign rsp_chan.data_out      = data_out_w;
   assign rsp_chan.prev_slot     = prev_slot_w;
   assign rsp_chan.next_slot     = next_slot_w;
   assign rsp_chan.slot_used     = slot_used_w;
   assign rsp_chan.head_slot     = head_slot_w;
   assign rsp_chan.tail_slot     = tail_slot_w;
   assign rsp_chan.element_count = count_w;

endmodule
